// ===== design/tod_clk_pkg.sv =====
// Shared types, constants and digit-split helper for the time-of-day clock.
package tod_clk_pkg;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_INC       = 2'd1,
        KIND_DEC       = 2'd2,
        KIND_SEC_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        DIG_SEC_ONES  = 3'd0,
        DIG_SEC_TENS  = 3'd1,
        DIG_MIN_ONES  = 3'd2,
        DIG_MIN_TENS  = 3'd3,
        DIG_HOUR_ONES = 3'd4,
        DIG_HOUR_TENS = 3'd5,
        DIG_SPARE_6   = 3'd6,
        DIG_SPARE_7   = 3'd7
    } digit_t;

    localparam logic [6:0] MIN_MAX     = 7'd59;
    localparam logic [6:0] SEC_MAX     = 7'd59;
    localparam logic [5:0] HOUR_MAX    = 6'd23;
    localparam logic [4:0] HOUR_RESET  = 5'd12;
    localparam logic [3:0] BLANK_DIGIT = 4'd15;
    localparam logic [3:0] DEC_BASE    = 4'd10;

    // Tens digit of a value below 64: (v * 13) >> 7.
    function automatic logic [3:0] tens_of(input logic [5:0] value);
        logic [9:0] prod;
        prod = {4'd0, value} * 10'd13;
        return {1'b0, prod[9:7]};
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] value);
        logic [5:0] tens_x10;
        tens_x10 = {2'd0, tens_of(value)} * {2'd0, DEC_BASE};
        return 4'(value - tens_x10);
    endfunction

endpackage

// ===== design/time_of_day_clock_with_digit_set_core.sv =====
// Top level: 24-hour time-of-day clock with digit set and blanking.
//
// A beat enters an input register, and in the next stage the hour, minute and
// second counters update and the six decimal digits go to the result register.
// One beat per cycle is accepted while the result channel does not stall; each
// beat passes the input register, then the result register. The clock resets to
// 12:00:00. Kind tick advances seconds with carry through minutes and hours;
// increment and decrement act on the minute or hour ones or tens with
// wrap at 59 and 23 and no carry; reset-seconds clears the seconds. With
// display off every digit reads 15 while the counters still update.
module time_of_day_clock_with_digit_set_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [2:0] s_digit_index,
    input  logic       s_display_on,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_sec_ones,
    output logic [3:0] m_sec_tens,
    output logic [3:0] m_min_ones,
    output logic [3:0] m_min_tens,
    output logic [3:0] m_hour_ones,
    output logic [3:0] m_hour_tens
);

    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [2:0] in_index_reg;
    logic       in_on_reg;

    logic [4:0] hour_reg;
    logic [5:0] min_reg;
    logic [5:0] sec_reg;
    logic [4:0] hour_next;
    logic [5:0] min_next;
    logic [5:0] sec_next;

    logic       out_valid_reg;
    logic [3:0] sec_ones_reg, sec_tens_reg, min_ones_reg;
    logic [3:0] min_tens_reg, hour_ones_reg, hour_tens_reg;

    logic       out_free;
    logic       advance;

    logic [6:0] min_wide;
    logic [6:0] sec_wide;
    logic [5:0] hour_wide;
    logic [6:0] min_up1, min_up10;
    logic [5:0] hour_up1, hour_up10;
    logic [5:0] min_dn1, min_dn10;
    logic [4:0] hour_dn1, hour_dn10;
    logic [6:0] sec_up;
    logic [6:0] min_carry;
    logic [5:0] hour_carry;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign min_wide  = {1'b0, min_reg};
    assign sec_wide  = {1'b0, sec_reg};
    assign hour_wide = {1'b0, hour_reg};

    assign min_up1   = (min_wide + 7'd1 > tod_clk_pkg::MIN_MAX) ? 7'd0 : min_wide + 7'd1;
    assign min_up10  = (min_wide + 7'd10 > tod_clk_pkg::MIN_MAX) ? 7'd0 : min_wide + 7'd10;
    assign hour_up1  = (hour_wide + 6'd1 > tod_clk_pkg::HOUR_MAX) ? 6'd0 : hour_wide + 6'd1;
    assign hour_up10 = (hour_wide + 6'd10 > tod_clk_pkg::HOUR_MAX) ? 6'd0
                     : hour_wide + 6'd10;
    assign min_dn1   = (min_reg < 6'd1) ? tod_clk_pkg::MIN_MAX[5:0] : min_reg - 6'd1;
    assign min_dn10  = (min_reg < 6'd10) ? tod_clk_pkg::MIN_MAX[5:0] : min_reg - 6'd10;
    assign hour_dn1  = (hour_reg < 5'd1) ? tod_clk_pkg::HOUR_MAX[4:0] : hour_reg - 5'd1;
    assign hour_dn10 = (hour_reg < 5'd10) ? tod_clk_pkg::HOUR_MAX[4:0] : hour_reg - 5'd10;

    assign sec_up     = (sec_wide + 7'd1 > tod_clk_pkg::SEC_MAX) ? 7'd0 : sec_wide + 7'd1;
    assign min_carry  = (sec_up == 7'd0) ? min_up1 : min_wide;
    assign hour_carry = (sec_up == 7'd0 && min_up1 == 7'd0) ? hour_up1 : hour_wide;

    always_comb begin
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        case (tod_clk_pkg::kind_t'(in_kind_reg))
            tod_clk_pkg::KIND_TICK: begin
                sec_next  = sec_up[5:0];
                min_next  = min_carry[5:0];
                hour_next = hour_carry[4:0];
            end
            tod_clk_pkg::KIND_INC: begin
                case (tod_clk_pkg::digit_t'(in_index_reg))
                    tod_clk_pkg::DIG_MIN_ONES:  min_next  = min_up1[5:0];
                    tod_clk_pkg::DIG_MIN_TENS:  min_next  = min_up10[5:0];
                    tod_clk_pkg::DIG_HOUR_ONES: hour_next = hour_up1[4:0];
                    tod_clk_pkg::DIG_HOUR_TENS: hour_next = hour_up10[4:0];
                    default: ;
                endcase
            end
            tod_clk_pkg::KIND_DEC: begin
                case (tod_clk_pkg::digit_t'(in_index_reg))
                    tod_clk_pkg::DIG_MIN_ONES:  min_next  = min_dn1;
                    tod_clk_pkg::DIG_MIN_TENS:  min_next  = min_dn10;
                    tod_clk_pkg::DIG_HOUR_ONES: hour_next = hour_dn1;
                    tod_clk_pkg::DIG_HOUR_TENS: hour_next = hour_dn10;
                    default: ;
                endcase
            end
            tod_clk_pkg::KIND_SEC_CLEAR: begin
                sec_next = 6'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hour_reg      <= tod_clk_pkg::HOUR_RESET;
            min_reg       <= 6'd0;
            sec_reg       <= 6'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                hour_reg      <= hour_next;
                min_reg       <= min_next;
                sec_reg       <= sec_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_index_reg <= s_digit_index;
            in_on_reg    <= s_display_on;
        end
        if (advance) begin
            if (in_on_reg) begin
                sec_ones_reg  <= tod_clk_pkg::ones_of(sec_next);
                sec_tens_reg  <= tod_clk_pkg::tens_of(sec_next);
                min_ones_reg  <= tod_clk_pkg::ones_of(min_next);
                min_tens_reg  <= tod_clk_pkg::tens_of(min_next);
                hour_ones_reg <= tod_clk_pkg::ones_of({1'b0, hour_next});
                hour_tens_reg <= tod_clk_pkg::tens_of({1'b0, hour_next});
            end else begin
                sec_ones_reg  <= tod_clk_pkg::BLANK_DIGIT;
                sec_tens_reg  <= tod_clk_pkg::BLANK_DIGIT;
                min_ones_reg  <= tod_clk_pkg::BLANK_DIGIT;
                min_tens_reg  <= tod_clk_pkg::BLANK_DIGIT;
                hour_ones_reg <= tod_clk_pkg::BLANK_DIGIT;
                hour_tens_reg <= tod_clk_pkg::BLANK_DIGIT;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_sec_ones  = sec_ones_reg;
    assign m_sec_tens  = sec_tens_reg;
    assign m_min_ones  = min_ones_reg;
    assign m_min_tens  = min_tens_reg;
    assign m_hour_ones = hour_ones_reg;
    assign m_hour_tens = hour_tens_reg;

endmodule

// ===== sim/tb_time_of_day_clock_with_digit_set_core.sv =====
// Testbench for the time-of-day clock core: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module tb_time_of_day_clock_with_digit_set_core;

    localparam int RANDOM_ITEMS = 1450;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef logic [5:0][3:0] digits_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } tod_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] idx;
        logic       on;
        logic       drain;
    } beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind = 2'd0;
    logic [2:0] s_digit_index = 3'd0;
    logic       s_display_on = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_sec_ones;
    logic [3:0] m_sec_tens;
    logic [3:0] m_min_ones;
    logic [3:0] m_min_tens;
    logic [3:0] m_hour_ones;
    logic [3:0] m_hour_tens;

    beat_t   pending_q[$];
    digits_t expect_q[$];
    tod_t    live_tod = '{hour: tod_clk_pkg::HOUR_RESET, min: 6'd0, sec: 6'd0};
    tod_t    plan_tod = '{hour: tod_clk_pkg::HOUR_RESET, min: 6'd0, sec: 6'd0};
    bit      hold_next = 1'b0;

    int          send_gap = 0;
    int          tx_calm = 0;
    int          stall_left = 0;
    int          rx_calm = 0;
    int          err_cnt = 0;
    int unsigned taken = 0;
    int unsigned launched = 0;
    int unsigned cycle_cnt = 0;

    string digit_names [6] = '{"sec_ones", "sec_tens", "min_ones", "min_tens",
                               "hour_ones", "hour_tens"};

    time_of_day_clock_with_digit_set_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_digit_index(s_digit_index),
        .s_display_on (s_display_on),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sec_ones   (m_sec_ones),
        .m_sec_tens   (m_sec_tens),
        .m_min_ones   (m_min_ones),
        .m_min_tens   (m_min_tens),
        .m_hour_ones  (m_hour_ones),
        .m_hour_tens  (m_hour_tens)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int wrap_step(int v, int step, int top, bit up);
        if (up) begin
            return (v + step > top) ? 0 : v + step;
        end
        return (v < step) ? top : v - step;
    endfunction

    task automatic step_time(inout tod_t t, input tod_clk_pkg::kind_t kind,
                             input logic [2:0] idx);
        int h;
        int m;
        int s;
        int step;
        h = int'(t.hour);
        m = int'(t.min);
        s = int'(t.sec);
        step = (idx == tod_clk_pkg::DIG_MIN_ONES || idx == tod_clk_pkg::DIG_HOUR_ONES)
               ? 1 : int'(tod_clk_pkg::DEC_BASE);
        case (kind)
            tod_clk_pkg::KIND_TICK: begin
                s = wrap_step(s, 1, int'(tod_clk_pkg::SEC_MAX), 1'b1);
                if (s == 0) begin
                    m = wrap_step(m, 1, int'(tod_clk_pkg::MIN_MAX), 1'b1);
                    if (m == 0) begin
                        h = wrap_step(h, 1, int'(tod_clk_pkg::HOUR_MAX), 1'b1);
                    end
                end
            end
            tod_clk_pkg::KIND_INC, tod_clk_pkg::KIND_DEC: begin
                case (idx)
                    tod_clk_pkg::DIG_MIN_ONES, tod_clk_pkg::DIG_MIN_TENS: begin
                        m = wrap_step(m, step, int'(tod_clk_pkg::MIN_MAX),
                                      kind == tod_clk_pkg::KIND_INC);
                    end
                    tod_clk_pkg::DIG_HOUR_ONES, tod_clk_pkg::DIG_HOUR_TENS: begin
                        h = wrap_step(h, step, int'(tod_clk_pkg::HOUR_MAX),
                                      kind == tod_clk_pkg::KIND_INC);
                    end
                    default: ;
                endcase
            end
            default: s = 0;
        endcase
        t.hour = 5'(h);
        t.min = 6'(m);
        t.sec = 6'(s);
    endtask

    function automatic digits_t show_time(tod_t t, logic on);
        if (!on) begin
            return {6{tod_clk_pkg::BLANK_DIGIT}};
        end
        return {4'(t.hour / tod_clk_pkg::DEC_BASE), 4'(t.hour % tod_clk_pkg::DEC_BASE),
                4'(t.min / tod_clk_pkg::DEC_BASE), 4'(t.min % tod_clk_pkg::DEC_BASE),
                4'(t.sec / tod_clk_pkg::DEC_BASE), 4'(t.sec % tod_clk_pkg::DEC_BASE)};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic rand_on();
        return $urandom_range(0, 9) != 0;
    endfunction

    task automatic add_beat(input tod_clk_pkg::kind_t kind, input logic [2:0] idx,
                            input logic on);
        beat_t b;
        b.kind = kind;
        b.idx = idx;
        b.on = on;
        b.drain = hold_next;
        hold_next = 1'b0;
        pending_q.push_back(b);
        step_time(plan_tod, kind, idx);
    endtask

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 50) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    // drive input beats
    always @(negedge aclk) begin : driver_p
        beat_t nxt;
        if (aresetn && !(s_valid && taken != launched)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && expect_q.size() != 0)) begin
                nxt = pending_q.pop_front();
                s_kind <= nxt.kind;
                s_digit_index <= nxt.idx;
                s_display_on <= nxt.on;
                s_valid <= 1'b1;
                launched <= launched + 1;
                if (tx_calm > 0) begin
                    tx_calm--;
                    send_gap = 0;
                end else begin
                    if ($urandom_range(0, 79) == 0) tx_calm = $urandom_range(30, 120);
                    send_gap = gap_len();
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // stall the result channel
    always @(negedge aclk) begin : sink_p
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm--;
            end else if ($urandom_range(0, 79) == 0) begin
                rx_calm = $urandom_range(30, 120);
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = gap_len();
            end
        end
    end

    always @(posedge aclk) begin : monitor_p
        digits_t got;
        digits_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expect_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending");
                end else begin
                    want = expect_q.pop_front();
                    got = {m_hour_tens, m_hour_ones, m_min_tens, m_min_ones,
                           m_sec_tens, m_sec_ones};
                    for (int i = 0; i < 6; i++) begin
                        if (got[i] !== want[i]) begin
                            report_mismatch($sformatf("%s got %0d want %0d",
                                                      digit_names[i], got[i], want[i]));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                step_time(live_tod, tod_clk_pkg::kind_t'(s_kind), s_digit_index);
                expect_q.push_back(show_time(live_tod, s_display_on));
                taken <= taken + 1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog_p
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus_p
        int n_directed;
        int r;
        int n;
        int th;
        logic [2:0] idx;

        add_beat(tod_clk_pkg::KIND_TICK, tod_clk_pkg::DIG_SEC_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_SEC_CLEAR, tod_clk_pkg::DIG_SEC_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_HOUR_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_HOUR_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_HOUR_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_HOUR_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_HOUR_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_HOUR_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_MIN_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_MIN_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_MIN_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_MIN_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_MIN_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_MIN_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_MIN_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_SEC_ONES, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_SEC_TENS, 1'b1);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_SPARE_6, 1'b1);
        add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_SPARE_7, 1'b1);
        add_beat(tod_clk_pkg::KIND_SEC_CLEAR, tod_clk_pkg::DIG_SPARE_7, 1'b0);
        add_beat(tod_clk_pkg::KIND_TICK, tod_clk_pkg::DIG_SPARE_6, 1'b0);
        add_beat(tod_clk_pkg::KIND_INC, tod_clk_pkg::DIG_HOUR_TENS, 1'b0);
        add_beat(tod_clk_pkg::KIND_TICK, tod_clk_pkg::DIG_MIN_ONES, 1'b1);
        n_directed = pending_q.size();
        hold_next = 1'b1;

        while (pending_q.size() < n_directed + RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) hold_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                n = $urandom_range(1, 70);
                repeat (n) add_beat(tod_clk_pkg::KIND_TICK, 3'($urandom_range(0, 7)),
                                    rand_on());
            end else if (r < 60) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    idx = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                      : 3'($urandom_range(2, 5));
                    add_beat($urandom_range(0, 1) ? tod_clk_pkg::KIND_INC
                                                  : tod_clk_pkg::KIND_DEC,
                             idx, rand_on());
                end
            end else if (r < 70) begin
                // walk to hh:59, then tick through the minute carry
                th = $urandom_range(0, 1) ? int'(tod_clk_pkg::HOUR_MAX)
                                          : $urandom_range(0, 23);
                while (plan_tod.hour != 5'(th)) begin
                    add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_HOUR_ONES, rand_on());
                end
                while (plan_tod.min != 6'(tod_clk_pkg::MIN_MAX)) begin
                    add_beat(tod_clk_pkg::KIND_DEC, tod_clk_pkg::DIG_MIN_ONES, rand_on());
                end
                add_beat(tod_clk_pkg::KIND_SEC_CLEAR, 3'($urandom_range(0, 7)), rand_on());
                n = int'(tod_clk_pkg::SEC_MAX) + 1 + $urandom_range(0, 3);
                repeat (n) add_beat(tod_clk_pkg::KIND_TICK, 3'($urandom_range(0, 7)),
                                    rand_on());
            end else if (r < 80) begin
                add_beat(tod_clk_pkg::KIND_SEC_CLEAR, 3'($urandom_range(0, 7)), rand_on());
                n = $urandom_range(0, 5);
                repeat (n) add_beat(tod_clk_pkg::KIND_TICK, 3'($urandom_range(0, 7)),
                                    rand_on());
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    add_beat(tod_clk_pkg::kind_t'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                end
            end
        end

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || taken != launched) @(posedge aclk);
        while (expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
